// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/kwt_pkg.sv -----
package kwt_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int FIELD_W = 16;
  localparam int KIND_W = 4;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int QUEUE_DEPTH = 4;
  localparam int NUM_KW = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_FUNCTION = 4'd0,
    KIND_LET      = 4'd1,
    KIND_TYPE     = 4'd2,
    KIND_RETURN   = 4'd3,
    KIND_EQ       = 4'd4,
    KIND_NUMBER   = 4'd5,
    KIND_IDENT    = 4'd6,
    KIND_SEMI     = 4'd7,
    KIND_COLON    = 4'd8,
    KIND_EOF      = 4'd9,
    KIND_UNKNOWN  = 4'd10
  } tok_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_WORD   = 2'd2
  } scan_mode_e;

  typedef struct packed {
    tok_kind_e          kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
  } tok_t;

  // One request's worth of results: one token, or two when both is set
  typedef struct packed {
    logic both;
    tok_t tok0;
    tok_t tok1;
  } rec_t;

  // Head of the queue as seen by the output side
  typedef struct packed {
    logic valid;
    rec_t rec;
  } q_head_t;

  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"f", "u", "n", "c", "t", "i", "o", "n"},
    '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "y", "p", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd8, 4'd3, 4'd4, 4'd6};

  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_UNDER = "_";

  // Keywords whose letter at position idx equals c
  function automatic logic [NUM_KW-1:0] kw_match(input logic [3:0] idx,
                                                 input logic [7:0] c);
    logic [NUM_KW-1:0] m;
    for (int k = 0; k < NUM_KW; k++) begin
      m[k] = (idx < KW_LEN[k]) && (KW_TEXT[k][idx[2:0]] == c);
    end
    return m;
  endfunction

  // Kind of a closed word: lowest keyword still alive at its full length
  function automatic tok_kind_e kw_kind(input logic [NUM_KW-1:0] alive,
                                        input logic [3:0] wlen);
    tok_kind_e kind;
    kind = KIND_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (alive[k] && (wlen == KW_LEN[k])) kind = tok_kind_e'(KIND_W'(k));
    end
    return kind;
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

// ----- sv/kwt_front.sv -----
module kwt_front #(
  parameter int POSITION_BITS = kwt_pkg::POSITION_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      char_byte,
  input  logic            end_of_source,
  output logic            push,
  output kwt_pkg::rec_t   rec
);

  kwt_pkg::scan_mode_e        mode, mode_next;
  logic [POSITION_BITS-1:0]   run_start, run_start_next;
  logic [POSITION_BITS-1:0]   byte_pos, byte_pos_next;
  logic [kwt_pkg::NUM_KW-1:0] alive, alive_next;
  logic [3:0]                 word_len, word_len_next;
  logic                       finished, finished_next;

  logic [POSITION_BITS-1:0]                 run_len;
  logic [POSITION_BITS+kwt_pkg::FIELD_W-1:0] pos_ext, len_ext;
  logic                                     has_run;
  kwt_pkg::tok_t                            close_tok, new_tok, eof_tok;
  logic                                     c_digit, c_letter, c_word, c_space;

  // Widen then cut, so any position width maps onto the 16-bit fields
  assign run_len = byte_pos - run_start;
  assign pos_ext = {{kwt_pkg::FIELD_W{1'b0}}, byte_pos};
  assign len_ext = {{kwt_pkg::FIELD_W{1'b0}}, run_len};

  assign c_digit  = kwt_pkg::is_numeral(char_byte);
  assign c_letter = kwt_pkg::is_letter(char_byte);
  assign c_space  = kwt_pkg::is_space(char_byte);
  assign c_word   = c_digit || c_letter || (char_byte == kwt_pkg::CH_UNDER);

  // Token for the run closed by this byte
  always_comb begin
    logic [POSITION_BITS+kwt_pkg::FIELD_W-1:0] start_ext;
    start_ext = {{kwt_pkg::FIELD_W{1'b0}}, run_start};
    has_run = 1'b0;
    close_tok.kind = kwt_pkg::KIND_NUMBER;
    unique case (mode)
      kwt_pkg::MODE_NUMBER: has_run = 1'b1;
      kwt_pkg::MODE_WORD: begin
        has_run = 1'b1;
        close_tok.kind = kwt_pkg::kw_kind(alive, word_len);
      end
      default: has_run = 1'b0;
    endcase
    close_tok.start  = start_ext[kwt_pkg::FIELD_W-1:0];
    close_tok.length = len_ext[kwt_pkg::FIELD_W-1:0];
  end

  // One-byte token and end token at the current position
  always_comb begin
    unique case (char_byte)
      kwt_pkg::CH_EQ:    new_tok.kind = kwt_pkg::KIND_EQ;
      kwt_pkg::CH_SEMI:  new_tok.kind = kwt_pkg::KIND_SEMI;
      kwt_pkg::CH_COLON: new_tok.kind = kwt_pkg::KIND_COLON;
      default:           new_tok.kind = kwt_pkg::KIND_UNKNOWN;
    endcase
    new_tok.start  = pos_ext[kwt_pkg::FIELD_W-1:0];
    new_tok.length = kwt_pkg::FIELD_W'(1);
    eof_tok.kind   = kwt_pkg::KIND_EOF;
    eof_tok.start  = pos_ext[kwt_pkg::FIELD_W-1:0];
    eof_tok.length = '0;
  end

  // Classify the byte and advance the scan state
  always_comb begin
    logic have_close, have_new;
    kwt_pkg::tok_t second;
    have_close     = 1'b0;
    have_new       = 1'b0;
    second         = new_tok;
    mode_next      = mode;
    run_start_next = run_start;
    byte_pos_next  = byte_pos;
    alive_next     = alive;
    word_len_next  = word_len;
    finished_next  = finished;
    if (accept && !finished) begin
      if (byte_pos != '1) byte_pos_next = byte_pos + POSITION_BITS'(1);
      if (end_of_source) begin
        have_close    = has_run;
        have_new      = 1'b1;
        second        = eof_tok;
        mode_next     = kwt_pkg::MODE_IDLE;
        finished_next = 1'b1;
      end else if ((mode == kwt_pkg::MODE_NUMBER) && c_digit) begin
        have_close = 1'b0;
      end else if ((mode == kwt_pkg::MODE_WORD) && c_word) begin
        alive_next = alive & kwt_pkg::kw_match(word_len, char_byte);
        if (word_len != 4'hF) word_len_next = word_len + 4'd1;
      end else begin
        have_close = has_run;
        mode_next  = kwt_pkg::MODE_IDLE;
        if (c_space) begin
          have_new = 1'b0;
        end else if (c_digit) begin
          mode_next      = kwt_pkg::MODE_NUMBER;
          run_start_next = byte_pos;
        end else if (c_letter) begin
          mode_next      = kwt_pkg::MODE_WORD;
          run_start_next = byte_pos;
          alive_next     = kwt_pkg::kw_match(4'd0, char_byte);
          word_len_next  = 4'd1;
        end else begin
          have_new = 1'b1;
        end
      end
    end
    push = have_close || have_new;
    rec.both = have_close && have_new;
    rec.tok0 = have_close ? close_tok : second;
    rec.tok1 = second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= kwt_pkg::MODE_IDLE;
      run_start <= '0;
      byte_pos  <= '0;
      alive     <= '1;
      word_len  <= '0;
      finished  <= 1'b0;
    end else begin
      mode      <= mode_next;
      run_start <= run_start_next;
      byte_pos  <= byte_pos_next;
      alive     <= alive_next;
      word_len  <= word_len_next;
      finished  <= finished_next;
    end
  end

endmodule

// ----- sv/kwt_queue.sv -----
module kwt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  kwt_pkg::rec_t    push_rec,
  input  logic             pop,
  output logic             full,
  output kwt_pkg::q_head_t head
);

  localparam int PTR_W = $clog2(kwt_pkg::QUEUE_DEPTH);

  kwt_pkg::rec_t    entries [kwt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push, do_pop;

  assign full      = (count == (PTR_W+1)'(kwt_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.rec  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && head.valid;

  // Store records between the scanner and the output side
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_rec;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

// ----- sv/kwt_back.sv -----
module kwt_back (
  input  logic             clk,
  input  logic             rst,
  input  kwt_pkg::q_head_t head,
  input  logic             out_ready,
  output logic             pop,
  output logic             out_valid,
  output kwt_pkg::tok_t    out_tok,
  output logic             out_last
);

  logic sel;
  logic fire;

  // Serialize a record into one or two results
  assign out_valid = head.valid;
  assign out_tok   = sel ? head.rec.tok1 : head.rec.tok0;
  assign out_last  = !head.rec.both || sel;
  assign fire      = out_valid && out_ready;
  assign pop       = fire && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (fire) begin
      sel <= !out_last;
    end
  end

endmodule

// ----- sv/keyword_tokenizer_core.sv -----
// A result is registered in the record queue before it is offered.
// One byte is taken per cycle while the four-entry record queue has room; a byte
// that yields two tokens is offered as two results from a single queue entry.
// Input ready drops only when that queue is full.
// Reset (synchronous, active high) clears the scan state and empties the queue.
module keyword_tokenizer_core #(
  parameter int POSITION_BITS = kwt_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [kwt_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] char_byte
  input  logic                               s_tlast,  // end_of_source
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [kwt_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [3:0] token_kind,
                                                       // [19:4] token_start,
                                                       // [35:20] token_length,
                                                       // [39:36] zero
  output logic                               m_tlast   // last_of_run
);

  logic             push, pop, full;
  kwt_pkg::rec_t    rec;
  kwt_pkg::q_head_t head;
  kwt_pkg::tok_t    tok;

  assign s_tready = !full;

  kwt_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (s_tvalid && s_tready),
    .char_byte     (s_tdata),
    .end_of_source (s_tlast),
    .push          (push),
    .rec           (rec)
  );

  kwt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (rec),
    .pop      (pop),
    .full     (full),
    .head     (head)
  );

  kwt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .out_ready (m_tready),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_tok   (tok),
    .out_last  (m_tlast)
  );

  // Pack the token fields, lowest field first
  assign m_tdata = {4'b0000, tok.length, tok.start, tok.kind};

endmodule

// ----- sv/kwt_checker.sv -----
`include "assert_macros.svh"

module kwt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [kwt_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tlast
);

  logic is_eof;
  logic out_wait;
  logic eof_ok;
  logic kind_ok;

  assign is_eof   = (m_tdata[3:0] == kwt_pkg::KIND_EOF);
  assign out_wait = m_tvalid && !m_tready;
  assign eof_ok   = m_tlast && (m_tdata[35:20] == 16'd0);
  assign kind_ok  = (m_tdata[3:0] <= kwt_pkg::KIND_UNKNOWN) && (m_tdata[39:36] == 4'd0);

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_wait, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // The end token closes its request and has no length
  `ASSERT_IMPLIES(a_eof_shape, clk, rst, m_tvalid && is_eof, eof_ok)

  // Kind is a defined code and padding stays clear
  `ASSERT_IMPLIES(a_kind_range, clk, rst, m_tvalid, kind_ok)

  // Nothing is offered right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid && s_tready)

endmodule

bind keyword_tokenizer_core kwt_checker u_kwt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- dv/kwt_token_check.sv -----
`timescale 1ns / 1ps

module kwt_token_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [kwt_pkg::IN_TDATA_W-1:0]      s_tdata,  // [7:0] char_byte
  input  logic                                s_tlast,  // end_of_source
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [kwt_pkg::OUT_TDATA_W-1:0]     m_tdata,  // [3:0] kind, [19:4] start,
                                                        // [35:20] length, [39:36] zero
  input  logic                                m_tlast,  // last_of_run
  output int                                  errors,
  output int                                  pending
);

  localparam logic [15:0] POS_LIMIT = 16'hFFFF;

  typedef struct {
    kwt_pkg::tok_kind_e kind;
    logic [15:0]        start;
    logic [15:0]        len;
    logic               last;
  } tok_want_t;

  // Tokens still owed by the block, oldest first
  tok_want_t tokens_due[$];
  // Tokens produced by the request being scanned
  tok_want_t burst[$];

  // Scanner state mirrored from the block
  kwt_pkg::scan_mode_e scan_mode   = kwt_pkg::MODE_IDLE;
  logic [15:0]         run_origin  = '0;
  logic [15:0]         next_pos    = '0;
  logic [63:0]         word_txt    = '0;
  logic [3:0]          word_len    = '0;
  logic                source_done = 1'b0;

  tok_want_t   want;
  logic [3:0]  got_kind;
  logic [15:0] got_start;
  logic [15:0] got_len;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic digit_char(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Keyword only when the whole word equals it; text holds the last eight bytes
  function automatic kwt_pkg::tok_kind_e word_kind(input logic [63:0] txt,
                                                   input logic [3:0] n);
    kwt_pkg::tok_kind_e k;
    k = kwt_pkg::KIND_IDENT;
    if (n == 4'd8 && txt == "function") k = kwt_pkg::KIND_FUNCTION;
    else if (n == 4'd3 && txt[23:0] == "let") k = kwt_pkg::KIND_LET;
    else if (n == 4'd4 && txt[31:0] == "type") k = kwt_pkg::KIND_TYPE;
    else if (n == 4'd6 && txt[47:0] == "return") k = kwt_pkg::KIND_RETURN;
    return k;
  endfunction

  task automatic add_tok(input kwt_pkg::tok_kind_e kind, input logic [15:0] start,
                         input logic [15:0] len);
    tok_want_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.last  = 1'b0;
    burst.push_back(t);
  endtask

  task automatic grow_word(input logic [7:0] c);
    word_txt = {word_txt[55:0], c};
    if (word_len != 4'd15) word_len = word_len + 4'd1;
  endtask

  // Close the open number or word, if any
  task automatic flush_run();
    if (scan_mode == kwt_pkg::MODE_NUMBER)
      add_tok(kwt_pkg::KIND_NUMBER, run_origin, next_pos - run_origin);
    else if (scan_mode == kwt_pkg::MODE_WORD)
      add_tok(word_kind(word_txt, word_len), run_origin, next_pos - run_origin);
    scan_mode = kwt_pkg::MODE_IDLE;
  endtask

  task automatic predict_item(input logic [7:0] c, input logic eos);
    burst.delete();
    if (source_done) return;
    if (eos) begin
      flush_run();
      add_tok(kwt_pkg::KIND_EOF, next_pos, 16'd0);
      source_done = 1'b1;
    end else begin
      if (scan_mode == kwt_pkg::MODE_NUMBER && digit_char(c)) begin
        // number goes on
      end else if (scan_mode == kwt_pkg::MODE_WORD &&
                   (alpha_char(c) || digit_char(c) || c == 8'h5F)) begin
        grow_word(c);
      end else begin
        flush_run();
        if (blank_char(c)) begin
          // skip
        end else if (digit_char(c)) begin
          scan_mode  = kwt_pkg::MODE_NUMBER;
          run_origin = next_pos;
        end else if (alpha_char(c)) begin
          scan_mode  = kwt_pkg::MODE_WORD;
          run_origin = next_pos;
          word_txt   = '0;
          word_len   = '0;
          grow_word(c);
        end else if (c == 8'h3D) begin
          add_tok(kwt_pkg::KIND_EQ, next_pos, 16'd1);
        end else if (c == 8'h3B) begin
          add_tok(kwt_pkg::KIND_SEMI, next_pos, 16'd1);
        end else if (c == 8'h3A) begin
          add_tok(kwt_pkg::KIND_COLON, next_pos, 16'd1);
        end else begin
          add_tok(kwt_pkg::KIND_UNKNOWN, next_pos, 16'd1);
        end
      end
      if (next_pos != POS_LIMIT) next_pos = next_pos + 16'd1;
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) tokens_due.push_back(burst[i]);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      // Compare an accepted token with the oldest one owed
      if (m_tvalid && m_tready) begin
        got_kind  = m_tdata[3:0];
        got_start = m_tdata[19:4];
        got_len   = m_tdata[35:20];
        if (tokens_due.size() == 0) begin
          $display({"%0t: unexpected token: expected none,",
                    " actual kind %0d start %0d len %0d last %0b"},
                   $realtime, got_kind, got_start, got_len, m_tlast);
          errors++;
        end else begin
          want = tokens_due.pop_front();
          if (got_kind != want.kind || got_start != want.start ||
              got_len != want.len || m_tlast != want.last) begin
            $display({"%0t: token mismatch: expected kind %0d start %0d len %0d last %0b,",
                      " actual kind %0d start %0d len %0d last %0b"},
                     $realtime, want.kind, want.start, want.len, want.last,
                     got_kind, got_start, got_len, m_tlast);
            errors++;
          end
        end
      end
      // Predict the tokens of an accepted request
      if (s_tvalid && s_tready) predict_item(s_tdata[7:0], s_tlast);
      pending = tokens_due.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  logic clk      = 1'b0;
  logic rst      = 1'b1;
  logic s_tvalid = 1'b0;
  logic [kwt_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tlast  = 1'b0;
  logic m_tready = 1'b0;
  logic s_tready;
  logic m_tvalid;
  logic [kwt_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;

  int errors;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int phase_items    = 0;

  logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  string near_words [16] = '{"function", "let", "type", "return", "le", "lets",
                             "functions", "typ", "types", "retur", "returns",
                             "Let", "TYPE", "f_n", "type1", "letx"};

  keyword_tokenizer_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  kwt_token_check u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .errors(errors), .pending(pending)
  );

  always #4 clk = ~clk;

  // Stall the token side at random
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one request, with random idle cycles ahead of it
  task automatic push_item(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    phase_items++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] word_byte();
    int p;
    p = $urandom_range(63);
    if (p < 26) return 8'(8'h61 + p);
    if (p < 52) return 8'(8'h41 + (p - 26));
    if (p < 62) return 8'(8'h30 + (p - 52));
    return 8'h5F;
  endfunction

  // One token-like fragment, then sometimes a separator
  task automatic send_fragment();
    int pick;
    int n;
    pick = $urandom_range(15);
    if (pick < 5) begin
      push_text(near_words[4'($urandom_range(15))]);
    end else if (pick < 8) begin
      // identifier, sometimes long enough to saturate the word length
      n = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
      push_item(8'(($urandom_range(1) ? 32'h61 : 32'h41) + $urandom_range(25)), 1'b0);
      for (int i = 1; i < n; i++) push_item(word_byte(), 1'b0);
    end else if (pick < 10) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
      for (int i = 0; i < n; i++) push_item(8'(8'h30 + $urandom_range(9)), 1'b0);
    end else if (pick < 13) begin
      push_item(pick == 10 ? 8'h3D : (pick == 11 ? 8'h3B : 8'h3A), 1'b0);
    end else begin
      // noise bytes of any value
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) push_item(8'($urandom_range(255)), 1'b0);
    end
    pick = $urandom_range(9);
    if (pick < 5) begin
      n = $urandom_range(2, 1);
      for (int i = 0; i < n; i++) push_item(blanks[3'($urandom_range(5))], 1'b0);
    end else if (pick < 7) begin
      push_item($urandom_range(2) == 0 ? 8'h3D : ($urandom_range(1) ? 8'h3B : 8'h3A), 1'b0);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    phase_items    = 0;
    while (phase_items < count) send_fragment();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: keywords, run closed by blank and by one-byte tokens, odd bytes
    push_text("function\tlet=7;return:type ");
    push_item(8'h00, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'hFF, 1'b0);

    // Random source text under each idle pattern
    run_phase(0, 0, 350);
    run_phase(78, 0, 350);
    run_phase(0, 78, 350);
    run_phase(29, 29, 350);

    // Long word, a number and one-byte tokens, then the end marker
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    push_text("abcdefghijklmnopq=42;let x");
    push_item(8'h00, 1'b1);

    // Requests after the end are dropped
    push_text("let=1");
    push_item(8'h41, 1'b1);
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
